// ===== rtl/core/bffa_pkg.sv =====
package bffa_pkg;

  localparam int unsigned NUM_BLOCKS  = 1024;
  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned MAP_WORDS   = NUM_BLOCKS / WORD_BITS;

  localparam int unsigned BIT_W  = $clog2(WORD_BITS);
  localparam int unsigned WORD_W = $clog2(MAP_WORDS);
  localparam int unsigned BLK_W  = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned ADDR_W = 22;
  localparam int unsigned STAT_W = 2;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ZERO    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NO_FREE = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_NO_RUN  = 2'd3;

  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } find_t;

  // lowest set bit of a word
  function automatic find_t first_set(logic [WORD_BITS-1:0] vec);
    find_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.found = 1'b1;
        res.idx   = BIT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/bffa_ram.sv =====
module bffa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bitmap_first_fit_block_allocator.sv =====
// First-fit allocator of contiguous blocks over a used/free bitmap held in a 32 x 32 RAM.
// Each request is accepted in S_IDLE and gets the zero and capacity tests in S_CHECK, then
// the scan: per bitmap word a RAM fetch in S_FETCH, then S_SCAN steps through each free
// run the word holds at or after the scan position, with a further step unless the last
// such run reaches the top bit of the word. A granted run is then marked with a
// read-modify-write (S_MRD, S_MWR) of each word it touches, and S_DONE loads the result
// register once the output is free. A request that fails a test skips the rest. The
// bitmap reads as all free after reset through per-word valid flops, so no clearing pass
// is needed. A new request may be accepted while a result waits on the output.
// total_blocks may be written at any idle time and takes effect with the next request;
// only whole 32-block words below it are searched.
module bitmap_first_fit_block_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bffa_pkg::CNT_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bffa_pkg::CNT_W-1:0]     request_count_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bffa_pkg::STAT_W-1:0]    status_o,
  output logic [bffa_pkg::BLK_W-1:0]     start_block_o,
  output logic [bffa_pkg::ADDR_W-1:0]    byte_address_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MRD   = 3'd4;
  localparam logic [2:0] S_MWR   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int unsigned WB  = bffa_pkg::WORD_BITS;
  localparam int unsigned BW  = bffa_pkg::BIT_W;
  localparam int unsigned WW  = bffa_pkg::WORD_W;
  localparam int unsigned KW  = bffa_pkg::BLK_W;
  localparam int unsigned CW  = bffa_pkg::CNT_W;
  localparam int unsigned NWW = WW + 1;

  localparam logic [CW-1:0]   MAX_CNT  = CW'(bffa_pkg::NUM_BLOCKS);
  localparam logic [BW:0]     WB_SEG   = (BW + 1)'(WB);
  localparam logic [BW-1:0]   LAST_BIT = BW'(WB - 1);
  localparam logic [bffa_pkg::ADDR_W-1:0] BYTES_A =
    bffa_pkg::ADDR_W'(bffa_pkg::BLOCK_BYTES);

  logic [2:0]                     state_q, state_d;
  logic [CW-1:0]                  req_q, req_d;
  logic [CW-1:0]                  total_q, total_d;
  logic [CW-1:0]                  used_q, used_d;
  logic [bffa_pkg::MAP_WORDS-1:0] wvalid_q, wvalid_d;
  logic [WW-1:0]                  word_q, word_d;
  logic [NWW-1:0]                 nwords_q, nwords_d;
  logic [WB-1:0]                  w_q, w_d;
  logic [BW-1:0]                  pos_q, pos_d;
  logic [CW-1:0]                  run_len_q, run_len_d;
  logic [KW-1:0]                  run_start_q, run_start_d;
  logic [KW-1:0]                  start_q, start_d;
  logic [WW-1:0]                  mword_q, mword_d;
  logic [bffa_pkg::STAT_W-1:0]    res_q, res_d;

  logic                           out_valid_q, out_valid_d;
  logic [bffa_pkg::STAT_W-1:0]    status_q, status_d;
  logic [KW-1:0]                  start_out_q, start_out_d;
  logic [bffa_pkg::ADDR_W-1:0]    addr_out_q, addr_out_d;

  logic                           ram_we, ram_re;
  logic [WW-1:0]                  ram_waddr, ram_raddr;
  logic [WB-1:0]                  ram_wdata, ram_rdata;

  logic [CW-1:0]                  eff, free_cnt;
  bffa_pkg::find_t                ff, fu;
  logic                           cont;
  logic [CW-1:0]                  base_len, new_len;
  logic [BW:0]                    seg;
  logic [KW-1:0]                  seg_start, end_blk;
  logic [BW-1:0]                  lo, hi;
  logic [WB-1:0]                  mark_mask, cur_word;

  bffa_ram #(
    .WIDTH (WB),
    .DEPTH (bffa_pkg::MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // capacity test
  assign eff      = (total_q > MAX_CNT) ? MAX_CNT : total_q;
  assign free_cnt = (eff > used_q) ? (eff - used_q) : '0;

  // one free run of the current word per cycle
  assign ff        = bffa_pkg::first_set(~w_q & (bffa_pkg::FULL_WORD << pos_q));
  assign fu        = bffa_pkg::first_set(w_q & (bffa_pkg::FULL_WORD << ff.idx));
  assign cont      = (ff.idx == pos_q) && (run_len_q != '0);
  assign base_len  = cont ? run_len_q : '0;
  assign seg       = (fu.found ? {1'b0, fu.idx} : WB_SEG) - {1'b0, ff.idx};
  assign new_len   = base_len + CW'(seg);
  assign seg_start = cont ? run_start_q : {word_q, ff.idx};

  // marking of the granted run
  assign end_blk   = KW'(CW'(start_q) + req_q - CW'(1));
  assign cur_word  = wvalid_q[mword_q] ? ram_rdata : '0;
  assign lo        = (mword_q == start_q[KW-1:BW]) ? start_q[BW-1:0] : '0;
  assign hi        = (mword_q == end_blk[KW-1:BW]) ? end_blk[BW-1:0] : LAST_BIT;
  assign mark_mask = (bffa_pkg::FULL_WORD << lo) & (bffa_pkg::FULL_WORD >> (LAST_BIT - hi));

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    total_d     = total_q;
    used_d      = used_q;
    wvalid_d    = wvalid_q;
    word_d      = word_q;
    nwords_d    = nwords_q;
    w_d         = w_q;
    pos_d       = pos_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    start_d     = start_q;
    mword_d     = mword_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    start_out_d = start_out_q;
    addr_out_d  = addr_out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = mword_q;
    ram_raddr   = mword_q;
    ram_wdata   = cur_word | mark_mask;

    if (cfg_we_i) begin
      total_d = cfg_wdata_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = request_count_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        start_d     = '0;
        word_d      = '0;
        pos_d       = '0;
        run_len_d   = '0;
        run_start_d = '0;
        nwords_d    = eff[CW-1:BW];
        if (req_q == '0) begin
          res_d   = bffa_pkg::STATUS_ZERO;
          state_d = S_DONE;
        end else if (req_q > free_cnt) begin
          res_d   = bffa_pkg::STATUS_NO_FREE;
          state_d = S_DONE;
        end else if (eff[CW-1:BW] == '0) begin
          res_d   = bffa_pkg::STATUS_NO_RUN;
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_d   = S_FETCH;
        end
      end
      S_FETCH: begin
        w_d     = wvalid_q[word_q] ? ram_rdata : '0;
        pos_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (ff.found && (new_len >= req_q)) begin
          start_d = seg_start;
          mword_d = seg_start[KW-1:BW];
          state_d = S_MRD;
        end else if (ff.found && fu.found) begin
          // run broken inside the word, look for the next one
          run_len_d = '0;
          pos_d     = fu.idx;
        end else begin
          if (ff.found) begin
            run_len_d   = new_len;
            run_start_d = seg_start;
          end else begin
            run_len_d = '0;
          end
          if (NWW'(word_q) + NWW'(1) == nwords_q) begin
            res_d   = bffa_pkg::STATUS_NO_RUN;
            state_d = S_DONE;
          end else begin
            word_d    = word_q + WW'(1);
            ram_re    = 1'b1;
            ram_raddr = word_q + WW'(1);
            state_d   = S_FETCH;
          end
        end
      end
      S_MRD: begin
        ram_re    = 1'b1;
        ram_raddr = mword_q;
        state_d   = S_MWR;
      end
      S_MWR: begin
        ram_we            = 1'b1;
        wvalid_d[mword_q] = 1'b1;
        if (mword_q == end_blk[KW-1:BW]) begin
          used_d  = used_q + req_q;
          res_d   = bffa_pkg::STATUS_OK;
          state_d = S_DONE;
        end else begin
          mword_d = mword_q + WW'(1);
          state_d = S_MRD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_q;
          start_out_d = start_q;
          addr_out_d  = bffa_pkg::ADDR_W'(start_q) * BYTES_A;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= MAX_CNT;
      used_q      <= '0;
      wvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      used_q      <= used_d;
      wvalid_q    <= wvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    word_q      <= word_d;
    nwords_q    <= nwords_d;
    w_q         <= w_d;
    pos_q       <= pos_d;
    run_len_q   <= run_len_d;
    run_start_q <= run_start_d;
    start_q     <= start_d;
    mword_q     <= mword_d;
    res_q       <= res_d;
    status_q    <= status_d;
    start_out_q <= start_out_d;
    addr_out_q  <= addr_out_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign start_block_o  = start_out_q;
  assign byte_address_o = addr_out_q;

endmodule

// ===== verif/allocation_checker.sv =====
module allocation_checker
  import bffa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [CNT_W-1:0]  request_count_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [STAT_W-1:0] status_i,
  input  logic [BLK_W-1:0]  start_block_i,
  input  logic [ADDR_W-1:0] byte_address_i,
  output int                pending_o,
  output int                error_count_o,
  output int                grant_count_o,
  output int                zero_count_o,
  output int                no_free_count_o,
  output int                no_run_count_o
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  start_block;
    logic [ADDR_W-1:0] byte_address;
  } alloc_result_t;

  logic [WORD_BITS-1:0] block_map_q [MAP_WORDS];
  logic [CNT_W-1:0]     used_blocks_q;
  logic [CNT_W-1:0]     total_blocks_q;
  alloc_result_t        expected_grants_q [$];
  int                   result_idx = 0;

  initial begin
    pending_o       = 0;
    error_count_o   = 0;
    grant_count_o   = 0;
    zero_count_o    = 0;
    no_free_count_o = 0;
    no_run_count_o  = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count_o++;
    $display("[%0t] result %0d: %s: got %0d, expected %0d", $time, result_idx, what, got, want);
  endtask

  // first-fit over whole words below the effective total, marks the run on success
  function automatic alloc_result_t grant_request(logic [CNT_W-1:0] req);
    int unsigned   eff;
    int unsigned   free_n;
    int unsigned   limit;
    int unsigned   run;
    int unsigned   run_start;
    int unsigned   b;
    int unsigned   blk;
    bit            found;
    alloc_result_t res;
    res       = '0;
    eff       = (total_blocks_q > NUM_BLOCKS) ? NUM_BLOCKS : total_blocks_q;
    free_n    = (eff > used_blocks_q) ? eff - used_blocks_q : 0;
    limit     = (eff / WORD_BITS) * WORD_BITS;
    run       = 0;
    run_start = 0;
    found     = 1'b0;
    if (req == '0) begin
      res.status = STATUS_ZERO;
    end else if (req > free_n) begin
      res.status = STATUS_NO_FREE;
    end else begin
      b = 0;
      while (b < limit && !found) begin
        if ((b % WORD_BITS) == 0 && block_map_q[b / WORD_BITS] == FULL_WORD) begin
          run = 0;
          b += WORD_BITS;
        end else begin
          if (block_map_q[b / WORD_BITS][b % WORD_BITS]) begin
            run = 0;
          end else begin
            if (run == 0) run_start = b;
            run++;
            if (run == req) found = 1'b1;
          end
          b++;
        end
      end
      if (!found) begin
        res.status = STATUS_NO_RUN;
      end else begin
        for (int i = 0; i < req; i++) begin
          blk = run_start + i;
          block_map_q[blk / WORD_BITS][blk % WORD_BITS] = 1'b1;
        end
        used_blocks_q    = used_blocks_q + req;
        res.status       = STATUS_OK;
        res.start_block  = BLK_W'(run_start);
        res.byte_address = ADDR_W'(run_start * BLOCK_BYTES);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    alloc_result_t predicted;
    if (!rst_ni) begin
      foreach (block_map_q[w]) block_map_q[w] = '0;
      used_blocks_q  = '0;
      total_blocks_q = CNT_W'(NUM_BLOCKS);
      expected_grants_q.delete();
      pending_o <= 0;
    end else begin
      // results leave before a request accepted on the same edge can be queued
      if (out_valid_i && out_ready_i) begin
        if (expected_grants_q.size() == 0) begin
          report_mismatch("result with no request pending, status", status_i, 0);
        end else begin
          want = expected_grants_q.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", status_i, want.status);
          if (start_block_i !== want.start_block)
            report_mismatch("start_block", start_block_i, want.start_block);
          if (byte_address_i !== want.byte_address)
            report_mismatch("byte_address", byte_address_i, want.byte_address);
        end
        result_idx++;
      end
      if (cfg_we_i) total_blocks_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        predicted = grant_request(request_count_i);
        case (predicted.status)
          STATUS_OK:      grant_count_o++;
          STATUS_ZERO:    zero_count_o++;
          STATUS_NO_FREE: no_free_count_o++;
          default:        no_run_count_o++;
        endcase
        expected_grants_q.push_back(predicted);
      end
      pending_o <= expected_grants_q.size();
    end
  end

endmodule

// ===== verif/bitmap_first_fit_block_allocator_tb.sv =====
module bitmap_first_fit_block_allocator_tb;
  import bffa_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASES       = 24;
  localparam int PHASE_ITEMS  = 53;
  localparam int REQ_MAX      = (1 << CNT_W) - 1;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CNT_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [CNT_W-1:0]  request_count;
  logic              out_valid;
  logic              out_ready;
  logic [STAT_W-1:0] status;
  logic [BLK_W-1:0]  start_block;
  logic [ADDR_W-1:0] byte_address;

  int pending;
  int errors;
  int grants;
  int zero_reqs;
  int no_free;
  int no_run;
  int sent_count    = 0;
  int setting_count = 0;
  int hold_count    = 0;
  int idle_cycles   = 0;
  int total;
  bit quiet         = 1'b0;
  bit hold_off      = 1'b0;

  always #10 clk = ~clk;

  bitmap_first_fit_block_allocator DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .request_count_i (request_count),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .start_block_o   (start_block),
    .byte_address_o  (byte_address)
  );

  allocation_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .request_count_i (request_count),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .status_i        (status),
    .start_block_i   (start_block),
    .byte_address_i  (byte_address),
    .pending_o       (pending),
    .error_count_o   (errors),
    .grant_count_o   (grants),
    .zero_count_o    (zero_reqs),
    .no_free_count_o (no_free),
    .no_run_count_o  (no_run)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [CNT_W-1:0] count);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    request_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // only written once every outstanding result has been taken
  task automatic apply_total(input logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  // mostly small runs so the map fills over the whole run
  function automatic logic [CNT_W-1:0] pick_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)       return '0;
    else if (roll < 70) return CNT_W'($urandom_range(1, 4));
    else if (roll < 85) return CNT_W'($urandom_range(5, 40));
    else if (roll < 93) return CNT_W'($urandom_range(41, 200));
    else                return CNT_W'($urandom_range(0, REQ_MAX));
  endfunction

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int stall;
      if (hold_off) begin
        hold_off = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    request_count <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset total, a zero-size request, oversized requests
    send_request('0);
    send_request(CNT_W'(REQ_MAX));
    send_request(CNT_W'(NUM_BLOCKS + 1));
    // nothing managed
    apply_total('0);
    send_request(CNT_W'(1));
    send_request('0);
    // total above the maximum is clamped
    apply_total(CNT_W'(REQ_MAX));
    send_request(CNT_W'(NUM_BLOCKS + 1));
    // less than one whole word: nothing searchable
    apply_total(CNT_W'(31));
    send_request(CNT_W'(1));
    send_request(CNT_W'(31));
    send_request(CNT_W'(32));
    // partial second word lies outside the window
    apply_total(CNT_W'(40));
    send_request(CNT_W'(1));
    send_request(CNT_W'(30));
    send_request(CNT_W'(2));
    send_request(CNT_W'(1));
    send_request(CNT_W'(8));
    send_request(CNT_W'(9));
    // run crossing a word boundary, then full words skipped
    apply_total(CNT_W'(100));
    send_request(CNT_W'(40));
    send_request(CNT_W'(24));
    send_request(CNT_W'(1));
    send_request('0);
    // total lowered below the used count
    apply_total(CNT_W'(20));
    send_request(CNT_W'(1));

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 2)          total = NUM_BLOCKS;
      else if (p == PHASES - 1)     total = REQ_MAX;
      else if ($urandom_range(0, 4) == 0) total = $urandom_range(0, REQ_MAX);
      else                          total = 76 + (p + 1) * 40 + $urandom_range(0, 40);
      apply_total(CNT_W'(total));
      quiet = ($urandom_range(0, 3) == 0);
      if (p == 3 || p == 14) begin
        // back-pressure the output while requests keep coming
        quiet    = 1'b1;
        hold_off = 1'b1;
        hold_count++;
      end
      repeat (PHASE_ITEMS) send_request(pick_request());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d allocation requests over %0d total_blocks settings, %0d long stalls",
             sent_count, setting_count, hold_count);
    $display("Outcomes: %0d granted, %0d zero-size, %0d over capacity, %0d without a free run",
             grants, zero_reqs, no_free, no_run);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
